>>> sv/bdd_pkg.sv
// Package for the ballistic drag deceleration block: drag tables in ROM form,
// fixed-point constants and the divider stage record. No dependencies.
package bdd_pkg;

  localparam int NUM_TABLES = 6;
  localparam int MAX_PTS    = 85;
  localparam int IDX_W      = 7;
  localparam int DIV_BITS   = 32;

  // Speed of sound in units that turn 2*speed (cm/s) into 1/40 Mach.
  localparam logic [10:0] MACH_DIV         = 11'd1715;
  localparam logic [17:0] OVER_LIMIT_SPEED = 18'd171500;
  localparam logic [15:0] K_NUM            = 16'd34209;
  // 2e14 = 2^15 * 5^14; the power of two is taken off as a shift.
  localparam logic [32:0] K5               = 33'd6103515625;
  localparam int          K_SHIFT          = 15;
  // Reciprocal of 1715 for exact quotients of values below 2^27.
  localparam logic [27:0] RECIP_M          = 28'd160278663;
  localparam int          RECIP_SH         = 38;

  localparam logic [IDX_W-1:0] PT_COUNT [NUM_TABLES] = '{
    7'd79, 7'd85, 7'd76, 7'd79, 7'd84, 7'd78
  };

  localparam logic [7:0] MACH_PT [NUM_TABLES][MAX_PTS] = '{
    '{0,2,4,6,8,10,12,14,16,18,20,22,24,28,29,30,31,32,33,34,35,36,37,38,39,40,41,42,43,44,45,46,
      48,50,52,54,56,58,60,62,64,66,68,70,72,74,76,78,80,82,84,86,88,90,92,94,96,98,100,
      104,108,112,116,120,124,128,132,136,140,144,148,152,156,160,168,176,184,192,200,
      0,0,0,0,0,0},
    '{0,2,4,6,8,10,12,14,16,18,20,22,24,26,28,30,31,32,33,34,35,36,37,38,39,40,41,42,43,44,45,46,
      47,48,50,52,54,56,58,60,62,64,66,68,70,72,74,76,78,80,82,84,86,88,90,92,94,96,98,100,
      102,104,106,108,110,112,114,116,118,120,124,128,132,136,140,144,148,152,156,160,168,176,
      184,192,200},
    '{0,2,4,6,8,10,12,14,16,18,20,22,24,26,28,30,32,34,35,36,37,38,39,40,41,42,43,44,
      46,48,50,52,54,56,58,60,62,64,66,68,70,72,74,76,78,80,82,84,86,88,90,92,94,96,98,100,
      104,108,112,116,120,124,128,132,136,140,144,148,152,156,160,168,176,184,192,200,
      0,0,0,0,0,0,0,0,0},
    '{0,2,4,6,8,10,12,14,16,18,20,22,24,26,28,30,32,34,35,36,37,38,39,40,41,42,43,44,45,46,47,48,
      49,50,52,54,56,58,60,62,64,66,68,70,72,74,76,78,80,82,84,86,88,90,92,94,96,98,100,
      104,108,112,116,120,124,128,132,136,140,144,148,152,156,160,168,176,184,192,200,
      0,0,0,0,0,0},
    '{0,2,4,6,8,10,12,14,16,18,20,22,24,26,28,29,30,31,32,33,34,35,36,37,38,39,40,41,42,43,44,45,
      46,48,50,52,54,56,60,62,64,66,68,70,72,74,76,78,80,82,84,86,88,90,92,94,96,98,100,
      102,104,106,108,110,112,114,116,118,120,124,128,132,136,140,144,148,152,156,160,168,176,
      184,192,200,0},
    '{0,2,4,6,8,10,12,14,16,18,20,22,24,26,28,30,32,33,34,35,36,37,38,39,40,41,42,43,44,45,46,
      48,50,52,54,56,58,60,62,64,66,68,70,72,74,76,78,80,82,84,86,88,90,92,94,96,98,100,
      104,108,112,116,120,124,128,132,136,140,144,148,152,156,160,168,176,184,192,200,
      0,0,0,0,0,0,0}
  };

  localparam logic [12:0] CD_PT [NUM_TABLES][MAX_PTS] = '{
    '{2629,2558,2487,2413,2344,2278,2214,2155,2104,2061,2032,2020,2034,2165,2230,2313,2417,2546,
      2706,2901,3136,3415,3734,4084,4448,4805,5136,5427,5677,5883,6053,6191,6393,6518,6589,6621,
      6625,6607,6573,6528,6474,6413,6347,6280,6210,6141,6072,6003,5934,5867,5804,5743,5685,5630,
      5577,5527,5481,5438,5397,5325,5264,5211,5168,5133,5105,5084,5067,5054,5040,5030,5022,5016,
      5010,5006,4998,4995,4992,4990,4988,0,0,0,0,0,0},
    '{2303,2298,2287,2271,2251,2227,2196,2156,2107,2048,1980,1905,1828,1758,1702,1669,1664,1667,
      1682,1711,1761,1831,2004,2589,3492,3983,4075,4103,4114,4106,4089,4068,4046,4021,3966,3904,
      3835,3759,3678,3594,3512,3432,3356,3282,3213,3149,3089,3033,2982,2933,2889,2846,2806,2768,
      2731,2696,2663,2632,2602,2572,2543,2515,2487,2460,2433,2408,2382,2357,2333,2309,2262,2217,
      2173,2132,2091,2052,2014,1978,1944,1912,1851,1794,1741,1693,1648},
    '{1710,1719,1727,1732,1734,1730,1718,1696,1668,1637,1603,1566,1529,1497,1473,1463,1489,1583,
      1672,1815,2051,2413,2884,3379,3785,4032,4147,4201,4278,4338,4373,4392,4403,4406,4401,4386,
      4362,4328,4286,4237,4182,4121,4057,3991,3926,3861,3800,3741,3684,3630,3578,3529,3481,3435,
      3391,3349,3269,3194,3125,3060,2999,2942,2889,2838,2790,2745,2703,2662,2624,2588,2553,2488,
      2429,2376,2326,2280,0,0,0,0,0,0,0,0,0},
    '{2617,2553,2491,2432,2376,2324,2278,2238,2205,2177,2155,2138,2126,2121,2122,2132,2154,2194,
      2229,2297,2449,2732,3141,3597,3994,4261,4402,4465,4490,4497,4494,4482,4464,4441,4390,4336,
      4279,4221,4162,4102,4042,3981,3919,3855,3788,3721,3652,3583,3515,3447,3381,3314,3249,3185,
      3122,3060,3000,2941,2883,2772,2668,2574,2487,2407,2333,2265,2202,2144,2089,2039,1991,1947,
      1905,1866,1794,1730,1673,1621,1574,0,0,0,0,0,0},
    '{1198,1197,1196,1194,1193,1194,1194,1194,1193,1193,1194,1193,1194,1197,1202,1207,1215,1226,
      1242,1266,1306,1368,1464,1660,2054,2993,3803,4015,4043,4034,4014,3987,3955,3884,3810,3732,
      3657,3580,3440,3376,3315,3260,3209,3160,3117,3078,3042,3010,2980,2951,2922,2892,2864,2835,
      2807,2779,2752,2725,2697,2670,2643,2615,2588,2561,2533,2506,2479,2451,2424,2368,2313,2258,
      2205,2154,2106,2060,2017,1975,1935,1861,1793,1730,1672,1618,0},
    '{2105,2105,2104,2104,2103,2103,2103,2103,2103,2102,2102,2102,2102,2102,2103,2103,2104,2104,
      2105,2106,2109,2183,2571,3358,4068,4378,4476,4493,4477,4450,4419,4353,4283,4208,4133,4059,
      3986,3915,3845,3777,3710,3645,3581,3519,3458,3400,3343,3288,3234,3182,3131,3081,3032,2983,
      2937,2891,2845,2802,2720,2642,2569,2499,2432,2368,2308,2251,2197,2147,2101,2058,2019,1983,
      1950,1890,1837,1791,1750,1713,0,0,0,0,0,0,0}
  };

  // One stage of the restoring divider.
  typedef struct packed {
    logic        v;
    logic        kill;
    logic        over;
    logic        pz;
    logic        sat;
    logic [65:0] rem;
    logic [48:0] e;
    logic [31:0] q;
  } div_st_t;

  // Control carried beside the data in stages 1 to 10.
  typedef struct packed {
    logic v;
    logic kill;
    logic over;
  } ctl_t;

endpackage

>>> sv/ballistic_drag_deceleration_top.sv
// Throughput one request per cycle while no finished result is held back by a stall.
// Front: table search, interpolation and exact division by 1715 by reciprocal over 7 stages.
// Back: split wide product over 3 stages, overflow check, then a 32-stage restoring divider.
// A stalled output result freezes the whole pipeline; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
// Depends on bdd_pkg.
module ballistic_drag_deceleration_top import bdd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_drag_model,
  input  logic [15:0] in_ballistic_coeff,
  input  logic [17:0] in_speed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_deceleration,
  output logic        out_mach_over_limit
);

  logic adv;

  ctl_t ctl_r [1:10];
  ctl_t ctl1_nxt;

  logic [17:0]        sp_r [1:7];
  logic [15:0]        bc_r [1:7];
  logic [2:0]         mdl_r;
  logic [MAX_PTS-1:0] cmp_r;
  logic [17:0]        sp_nxt;
  logic [2:0]         mdl_nxt;
  logic [MAX_PTS-1:0] cmp_nxt;

  logic [12:0]        pcd_r [2:6];
  logic [1:0]         k_r [2:6];
  logic               first_r [2:6];
  logic signed [13:0] diff_r;
  logic [13:0]        num_r;
  logic [13:0]        den_r;
  logic [12:0]        pcd_nxt;
  logic [1:0]         k_nxt;
  logic               first_nxt;
  logic signed [13:0] diff_nxt;
  logic [13:0]        num_nxt;
  logic [13:0]        den_nxt;

  logic [26:0] acc_r [3:4];
  logic [26:0] acc_nxt;
  logic [15:0] q1_r [4:6];
  logic [15:0] q1_nxt;
  logic [10:0] r1_r;
  logic [10:0] r1_nxt;
  logic [15:0] q2_r;
  logic [15:0] q2_nxt;
  logic [28:0] cdf_r;
  logic [28:0] cdf_nxt;

  logic [33:0] a_r, a_nxt;
  logic [46:0] b_r, b_nxt;
  logic [48:0] e_r [8:10];
  logic [48:0] e_nxt;
  logic [57:0] plo_r, plo_nxt;
  logic [56:0] phi_r, phi_nxt;
  logic [65:0] n_r, n_nxt;
  logic        pz_r, pz_nxt;

  div_st_t dv_r   [0:DIV_BITS];
  div_st_t dv_nxt [1:DIV_BITS];
  div_st_t dv0_nxt;

  logic        out_valid_r;
  logic [31:0] dec_r, dec_nxt;
  logic        over_r;

  // The pipeline moves unless a finished result is held back.
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Stage 1: range checks and threshold compares against every table point.
  always_comb begin
    logic        model_ok;
    logic        over;
    logic [18:0] thr;
    model_ok = (in_drag_model < 3'(NUM_TABLES));
    over     = (in_speed >= OVER_LIMIT_SPEED);
    ctl1_nxt.v    = in_valid;
    ctl1_nxt.kill = !model_ok || over;
    ctl1_nxt.over = model_ok && over;
    mdl_nxt = model_ok ? in_drag_model : 3'd0;
    sp_nxt  = ctl1_nxt.kill ? 18'd0 : in_speed;
    for (int i = 0; i < MAX_PTS; i++) begin
      thr = 19'(MACH_PT[mdl_nxt][i]) * 19'(MACH_DIV);
      cmp_nxt[i] = (IDX_W'(i + 1) < PT_COUNT[mdl_nxt]) && ({sp_nxt, 1'b0} <= thr);
    end
  end

  // Stage 2: first point at or above the query, table reads, interpolation terms.
  always_comb begin
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  pidx;
    logic [7:0]        pm;
    logic [7:0]        nm;
    logic [7:0]        dm;
    logic [12:0]       ncd;
    logic [18:0]       pm_th;
    logic signed [20:0] num_s;
    idx = PT_COUNT[mdl_r] - IDX_W'(1);
    for (int i = MAX_PTS - 1; i >= 0; i--) begin
      if (cmp_r[i]) begin
        idx = IDX_W'(i);
      end
    end
    first_nxt = (idx == '0);
    pidx      = first_nxt ? idx : idx - IDX_W'(1);
    pm        = MACH_PT[mdl_r][pidx];
    nm        = MACH_PT[mdl_r][idx];
    pcd_nxt   = CD_PT[mdl_r][pidx];
    ncd       = CD_PT[mdl_r][idx];
    dm        = nm - pm;
    // Table spacings are one, two, four or eight steps.
    case (dm)
      8'd2:    k_nxt = 2'd1;
      8'd4:    k_nxt = 2'd2;
      8'd8:    k_nxt = 2'd3;
      default: k_nxt = 2'd0;
    endcase
    den_nxt  = 14'(MACH_DIV) << k_nxt;
    diff_nxt = $signed({1'b0, ncd}) - $signed({1'b0, pcd_nxt});
    pm_th    = 19'(pm) * 19'(MACH_DIV);
    num_s    = $signed({2'b0, sp_r[1], 1'b0}) - $signed({2'b0, pm_th});
    if (num_s < 0) begin
      num_nxt = 14'd0;
    end else if (num_s > $signed({7'b0, den_nxt})) begin
      num_nxt = den_nxt;
    end else begin
      num_nxt = num_s[13:0];
    end
  end

  // Stage 3: interpolation numerator.
  always_comb begin
    logic [26:0]        t1;
    logic signed [28:0] t2;
    logic signed [29:0] acc_s;
    t1    = 27'(pcd_r[2]) * 27'(den_r);
    t2    = 29'(diff_r) * 29'($signed({1'b0, num_r}));
    acc_s = $signed({3'b0, t1}) + 30'(t2);
    acc_nxt = (acc_s < 0) ? 27'd0 : acc_s[26:0];
  end

  // Stages 4 to 7: divide by 1715 in two exact reciprocal steps, then by the spacing.
  always_comb begin
    logic [54:0] prod1;
    logic [54:0] prod2;
    logic [26:0] r1_w;
    logic [31:0] cdq;
    prod1   = 55'(acc_r[3]) * 55'(RECIP_M);
    q1_nxt  = prod1[RECIP_SH+15:RECIP_SH];
    r1_w    = acc_r[4] - 27'(q1_r[4]) * 27'(MACH_DIV);
    r1_nxt  = r1_w[10:0];
    prod2   = 55'({r1_r, 16'b0}) * 55'(RECIP_M);
    q2_nxt  = prod2[RECIP_SH+15:RECIP_SH];
    cdq     = {q1_r[6], 16'b0} + {16'b0, q2_r};
    cdf_nxt = first_r[6] ? {pcd_r[6], 16'b0} : 29'(cdq >> k_r[6]);
  end

  // Stages 8 to 10: drag product in partial products, and the divisor.
  always_comb begin
    logic [80:0] p;
    a_nxt   = 34'(K_NUM) * 34'(sp_r[7]);
    b_nxt   = 47'(cdf_r) * 47'(sp_r[7]);
    e_nxt   = 49'(K5) * 49'(bc_r[7]);
    plo_nxt = 58'(a_r) * 58'(b_r[23:0]);
    phi_nxt = 57'(a_r) * 57'(b_r[46:24]);
    p       = 81'(plo_r) + (81'(phi_r) << 24);
    n_nxt   = p[80:K_SHIFT];
    pz_nxt  = (p == '0);
  end

  // Stage 11: overflow check seeds the divider.
  always_comb begin
    dv0_nxt.v    = ctl_r[10].v;
    dv0_nxt.kill = ctl_r[10].kill;
    dv0_nxt.over = ctl_r[10].over;
    dv0_nxt.pz   = pz_r;
    dv0_nxt.sat  = !pz_r && ({15'b0, n_r} >= {e_r[10], 32'b0});
    dv0_nxt.rem  = n_r;
    dv0_nxt.e    = e_r[10];
    dv0_nxt.q    = '0;
  end

  // Divider: one quotient bit per stage, most significant first.
  always_comb begin
    logic [80:0] sh;
    for (int j = 0; j < DIV_BITS; j++) begin
      dv_nxt[j+1] = dv_r[j];
      sh = {32'b0, dv_r[j].e} << (DIV_BITS - 1 - j);
      if (!dv_r[j].sat && ({15'b0, dv_r[j].rem} >= sh)) begin
        dv_nxt[j+1].rem = dv_r[j].rem - sh[65:0];
        dv_nxt[j+1].q[DIV_BITS-1-j] = 1'b1;
      end
    end
  end

  // Final result selection.
  always_comb begin
    if (dv_r[DIV_BITS].kill || dv_r[DIV_BITS].pz) begin
      dec_nxt = 32'd0;
    end else if (dv_r[DIV_BITS].sat) begin
      dec_nxt = '1;
    end else begin
      dec_nxt = dv_r[DIV_BITS].q;
    end
  end

  // Pipeline registers: reset clears the valid bits only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 1; j <= 10; j++) begin
        ctl_r[j].v <= 1'b0;
      end
      for (int j = 0; j <= DIV_BITS; j++) begin
        dv_r[j].v <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      ctl_r[1] <= ctl1_nxt;
      for (int j = 2; j <= 10; j++) begin
        ctl_r[j] <= ctl_r[j-1];
      end
      sp_r[1] <= sp_nxt;
      bc_r[1] <= in_ballistic_coeff;
      for (int j = 2; j <= 7; j++) begin
        sp_r[j] <= sp_r[j-1];
        bc_r[j] <= bc_r[j-1];
      end
      mdl_r <= mdl_nxt;
      cmp_r <= cmp_nxt;
      pcd_r[2]   <= pcd_nxt;
      k_r[2]     <= k_nxt;
      first_r[2] <= first_nxt;
      for (int j = 3; j <= 6; j++) begin
        pcd_r[j]   <= pcd_r[j-1];
        k_r[j]     <= k_r[j-1];
        first_r[j] <= first_r[j-1];
      end
      diff_r   <= diff_nxt;
      num_r    <= num_nxt;
      den_r    <= den_nxt;
      acc_r[3] <= acc_nxt;
      acc_r[4] <= acc_r[3];
      q1_r[4]  <= q1_nxt;
      q1_r[5]  <= q1_r[4];
      q1_r[6]  <= q1_r[5];
      r1_r     <= r1_nxt;
      q2_r     <= q2_nxt;
      cdf_r    <= cdf_nxt;
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      e_r[8]   <= e_nxt;
      e_r[9]   <= e_r[8];
      e_r[10]  <= e_r[9];
      plo_r    <= plo_nxt;
      phi_r    <= phi_nxt;
      n_r      <= n_nxt;
      pz_r     <= pz_nxt;
      dv_r[0]  <= dv0_nxt;
      for (int j = 1; j <= DIV_BITS; j++) begin
        dv_r[j] <= dv_nxt[j];
      end
      out_valid_r <= dv_r[DIV_BITS].v;
      dec_r       <= dec_nxt;
      over_r      <= dv_r[DIV_BITS].over;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_deceleration    = dec_r;
  assign out_mach_over_limit = over_r;

`ifndef SYNTH
  // An over-limit result always carries zero deceleration.
  a_over_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mach_over_limit |-> out_deceleration == 32'd0)
    else $error("over-limit result with nonzero deceleration");

  // A request leaving the divider reaches the output register.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    adv && dv_r[DIV_BITS].v |=> out_valid)
    else $error("divider output lost");

  // A saturated divider stage never collects quotient bits.
  a_sat_q: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[DIV_BITS].v && dv_r[DIV_BITS].sat |-> dv_r[DIV_BITS].q == 32'd0)
    else $error("quotient bits set on saturated request");
`endif

endmodule

>>> verif/bdd_result_checker.sv
`timescale 1ns / 1ps
// Checker for the ballistic drag deceleration block: watches both channels,
// predicts each deceleration from the drag tables and compares. Depends on bdd_pkg.
module bdd_result_checker import bdd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_drag_model,
  input  logic [15:0] in_ballistic_coeff,
  input  logic [17:0] in_speed,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_deceleration,
  input  logic        out_mach_over_limit,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] decel;
    logic        over;
  } drag_result_t;

  drag_result_t decel_expect_q[$];

  // Interpolated drag coefficient, scaled deceleration and saturation.
  function automatic drag_result_t predict_decel(logic [2:0] model, logic [15:0] bc,
                                                 logic [17:0] speed);
    drag_result_t r;
    int           n;
    int           i;
    longint       pm, nm, pcd, ncd, num, den, acc;
    logic [127:0] cdf, prod, dvsr, quot;
    r = '0;
    if (model >= NUM_TABLES) return r;
    if (speed >= OVER_LIMIT_SPEED) begin
      r.over = 1'b1;
      return r;
    end
    n = int'(PT_COUNT[model]);
    for (i = 0; i + 1 < n; i++) begin
      if (longint'(MACH_PT[model][i]) * 1715 >= 2 * longint'(speed)) break;
    end
    if (i == 0) begin
      // Below the first point: that point's coefficient with no interpolation.
      cdf = 128'(CD_PT[model][0]) << 16;
    end else begin
      pm  = longint'(MACH_PT[model][i-1]);
      nm  = longint'(MACH_PT[model][i]);
      pcd = longint'(CD_PT[model][i-1]);
      ncd = longint'(CD_PT[model][i]);
      num = 2 * longint'(speed) - 1715 * pm;
      den = 1715 * ((nm > pm) ? (nm - pm) : 1);
      if (num < 0) num = 0;
      if (num > den) num = den;
      acc = pcd * den + (ncd - pcd) * num;
      if (acc < 0) acc = 0;
      cdf = (128'(acc) << 16) / 128'(den);
    end
    prod = 128'(34209) * cdf * 128'(speed) * 128'(speed);
    if (prod == 0) begin
      r.decel = '0;
    end else if (bc == 0) begin
      r.decel = 32'hFFFF_FFFF;
    end else begin
      dvsr = 128'(64'd200000000000000) * 128'(bc);
      quot = prod / dvsr;
      r.decel = (quot > 128'h FFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
    end
    return r;
  endfunction

  assign pending = decel_expect_q.size();

  // Predict on each accepted request, compare on each accepted result.
  always @(posedge clk) begin
    drag_result_t exp_r;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        decel_expect_q.push_back(predict_decel(in_drag_model, in_ballistic_coeff, in_speed));
      if (out_valid && !out_stall) begin
        if (decel_expect_q.size() == 0) begin
          $error("unexpected result: deceleration %0d over %0d",
                 out_deceleration, out_mach_over_limit);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = decel_expect_q.pop_front();
          if (exp_r.decel !== out_deceleration) begin
            $error("deceleration expected %0d actual %0d", exp_r.decel, out_deceleration);
            fail_count <= fail_count + 1;
          end
          if (exp_r.over !== out_mach_over_limit) begin
            $error("mach_over_limit expected %0d actual %0d", exp_r.over,
                   out_mach_over_limit);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> verif/tb_ballistic_drag_deceleration_top.sv
`timescale 1ns / 1ps
// Testbench top for the ballistic drag deceleration block: clock, reset, directed
// and random requests, receiver stalls and the verdict. Depends on bdd_pkg, the checker.
module tb_ballistic_drag_deceleration_top;
  import bdd_pkg::*;

  localparam int LATENCY     = 44;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_drag_model;
  logic [15:0] in_ballistic_coeff;
  logic [17:0] in_speed;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_deceleration;
  logic        out_mach_over_limit;
  int          fail_count;
  int          pending;
  int          cycle_cnt;
  logic        no_idle;
  logic        hold_req;

  ballistic_drag_deceleration_top dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_drag_model, .in_ballistic_coeff, .in_speed,
    .out_valid, .out_stall, .out_deceleration, .out_mach_over_limit
  );

  bdd_result_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_drag_model, .in_ballistic_coeff, .in_speed,
    .out_valid, .out_stall, .out_deceleration, .out_mach_over_limit, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on total run length.
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_query(logic [2:0] model, logic [15:0] bc, logic [17:0] speed);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_drag_model      <= model;
    in_ballistic_coeff <= bc;
    in_speed           <= speed;
    do @(posedge clk); while (in_stall);
  endtask

  // Receiver: random stall per result, plus one long hold-off on request.
  initial begin
    int w;
    out_stall <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end
      w = no_idle ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && !hold_req);
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [2:0]  m;
    logic [17:0] s;
    int          r;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_drag_model      <= '0;
    in_ballistic_coeff <= '0;
    in_speed           <= '0;
    no_idle            = 1'b0;
    hold_req           = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: speed zero, Mach limit edges, exact table points, odd models and BC.
    send_query(3'd0, 16'd16384, 18'd0);
    send_query(3'd0, 16'd16384, 18'd1);
    send_query(3'd1, 16'd1, 18'd1715);
    send_query(3'd2, 16'd65535, 18'd171499);
    send_query(3'd3, 16'd16384, 18'd171500);
    send_query(3'd4, 16'd1, 18'd262143);
    send_query(3'd6, 16'd16384, 18'd34300);
    send_query(3'd7, 16'd65535, 18'd262143);
    send_query(3'd5, 16'd0, 18'd50000);
    send_query(3'd0, 16'd0, 18'd0);
    send_query(3'd4, 16'd1, 18'd171499);
    send_query(3'd1, 16'd65535, 18'd1);
    send_query(3'd2, 16'd8192, 18'd34300);
    send_query(3'd3, 16'd100, 18'd857);
    send_query(3'd5, 16'd32768, 18'd100000);
    send_query(3'd0, 16'd5000, 18'd24010);
    send_query(3'd4, 16'd40000, 18'd130340);
    send_query(3'd1, 16'd2, 18'd262142);

    // Random requests, with one burst against a long receiver hold-off.
    for (int k = 0; k < 900; k++) begin
      if (k == 450) hold_req = 1'b1;
      no_idle = (k >= 200 && k < 260) || (k >= 450 && k < 520);
      r = $urandom_range(0, 99);
      m = (r < 5) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      r = $urandom_range(0, 99);
      if (r < 10)      s = 18'($urandom_range(0, 3000));
      else if (r < 85) s = 18'($urandom_range(0, 171499));
      else             s = 18'($urandom);
      r = $urandom_range(0, 99);
      send_query(m, (r < 2) ? 16'd0 : ((r < 10) ? 16'($urandom_range(1, 64)) : 16'($urandom)),
                 s);
    end
    in_valid <= 1'b0;
    no_idle  = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
